// ===== rtl/core/cuckoo_pkg.sv =====
// cuckoo_pkg: types, constants and hash step functions for the cuckoo hash table
// no dependencies
package cuckoo_pkg;

	localparam int SLOTS_LOG2_DEF     = 11;
	localparam int ENTRY_CAPACITY_DEF = 1023;
	localparam int MAX_ROUNDS_DEF     = 20;

	localparam logic [31:0] EVEN_SEED = 32'hdeadbeef;
	localparam logic [31:0] ODD_SEED  = 32'hdeadbeef + 32'd8 + 32'h55555555;
	localparam logic [31:0] LARSON_M  = 32'd101;

	localparam logic [0:0] OP_INSERT = 1'b0;
	localparam logic [0:0] OP_FIND   = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_DROPPED   = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [0:0]  operation;
		logic [63:0] key;
		logic [63:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] found_value;
		logic [63:0] dropped_key;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_HASH,
		S_SLOT_RD,
		S_SLOT_WAIT,
		S_ENTRY_RD,
		S_ENTRY_WAIT,
		S_FIND_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] key;
	} hash_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] even_h;
		logic [31:0] odd_c;
	} hash_rsp_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
		logic [63:0] d;
		begin
			d = {x, x} << r;
			return d[63:32];
		end
	endfunction

	// one mix step: x ^= y; x -= rot(y, r)
	function automatic logic [31:0] mix_step(input logic [31:0] x, input logic [31:0] y,
			input logic [4:0] r);
		return (x ^ y) - rotl32(y, r);
	endfunction

endpackage

// ===== rtl/core/cuckoo_ram.sv =====
// cuckoo_ram: generic single port RAM with registered read
// no dependencies
module cuckoo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/core/cuckoo_hash.sv =====
// cuckoo_hash: iterative hash unit, one shared multiply-add then one shared mix step a cycle
// depends on cuckoo_pkg
module cuckoo_hash (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cuckoo_pkg::hash_req_t req,
	output cuckoo_pkg::hash_rsp_t rsp
);
	import cuckoo_pkg::*;

	logic [3:0]  step_q;
	logic        busy_q;
	logic [63:0] key_q;
	logic [31:0] h_q, a_q, b_q, c_q;
	logic [7:0]  byte_sel;
	logic [31:0] m_x, m_y, m_r;
	logic [4:0]  rot;

	assign byte_sel = key_q[8*step_q[2:0] +: 8];

	// shared mix unit: operand choice per step
	always_comb begin
		unique case (step_q)
			4'd7:  begin m_x = c_q; m_y = b_q; rot = 5'd14; end
			4'd8:  begin m_x = a_q; m_y = c_q; rot = 5'd11; end
			4'd9:  begin m_x = b_q; m_y = a_q; rot = 5'd25; end
			4'd10: begin m_x = c_q; m_y = b_q; rot = 5'd16; end
			4'd11: begin m_x = a_q; m_y = c_q; rot = 5'd4;  end
			4'd12: begin m_x = b_q; m_y = a_q; rot = 5'd14; end
			4'd13: begin m_x = c_q; m_y = b_q; rot = 5'd24; end
			default: begin m_x = c_q; m_y = b_q; rot = 5'd14; end
		endcase
		m_r = mix_step(m_x, m_y, rot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 4'd1;
			if (step_q == 4'd13) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			key_q <= req.key;
			h_q   <= EVEN_SEED;
			a_q   <= ODD_SEED + req.key[31:0];
			b_q   <= ODD_SEED + req.key[63:32];
			c_q   <= ODD_SEED;
		end else if (busy_q) begin
			if (step_q < 4'd7) begin
				h_q <= h_q * LARSON_M + {24'd0, byte_sel};
			end else begin
				unique case (step_q)
					4'd8, 4'd11: a_q <= m_r;
					4'd9, 4'd12: b_q <= m_r;
					default:     c_q <= m_r;
				endcase
			end
		end
	end

	assign rsp.done   = busy_q && step_q == 4'd13;
	assign rsp.even_h = h_q[15:0] ^ h_q[31:16];
	assign rsp.odd_c  = m_r ^ {16'd0, m_r[31:16]};

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.start && busy_q)) else $error("hash restarted while busy");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !busy_q) else $error("hash ran past its last step");
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(req.start)) else $error("hash started without request");
endmodule

// ===== rtl/core/cuckoo_hash_table.sv =====
// cuckoo_hash_table: top level, sequencer with slot and entry memories
// depends on cuckoo_pkg, cuckoo_hash, cuckoo_ram
//
// channel  direction  signals
// cmd      in         start, busy, cmd
// result   out        result_valid, result
// cfg      in         cfg_valid, cfg_ready, cfg_data
//
// after reset a clearing pass over all 2^SLOTS_LOG2 slots empties the slot table; busy is high.
// each hash run goes through the shared hash unit; after the transfer:
// find: the even slot is read first, the odd slot only when the even slot does not hold the key.
// insert: up to 2*MAX_ROUNDS displacements; when the store is full the walk is skipped.
// results are strobed for one cycle; the receiver cannot stall.
module cuckoo_hash_table #(
	parameter int SLOTS_LOG2     = cuckoo_pkg::SLOTS_LOG2_DEF,
	parameter int ENTRY_CAPACITY = cuckoo_pkg::ENTRY_CAPACITY_DEF,
	parameter int MAX_ROUNDS     = cuckoo_pkg::MAX_ROUNDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cuckoo_pkg::cmd_t    cmd,
	output logic                result_valid,
	output cuckoo_pkg::result_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [3:0]          cfg_data
);
	import cuckoo_pkg::*;

	localparam int SD  = 1 << SLOTS_LOG2;
	localparam int EW  = $clog2(ENTRY_CAPACITY + 1);
	localparam int ED  = 1 << EW;
	localparam int RW  = $clog2(2 * MAX_ROUNDS + 1);

	state_t state_q, state_d;
	logic [3:0]            log2_q;
	logic [SLOTS_LOG2-1:0] clr_q, slot_q;
	logic [EW:0]           count_q;
	logic [EW-1:0]         carried_q, i1_q;
	logic [RW-1:0]         pushes_q;
	logic                  odd_q;
	cmd_t                  cmd_q;
	logic                  store_full;

	hash_req_t hreq;
	hash_rsp_t hrsp;

	logic                  s_we;
	logic [SLOTS_LOG2-1:0] s_addr;
	logic [EW-1:0]         s_wdata, s_rdata;
	logic                  e_we;
	logic [EW-1:0]         e_addr;
	logic [63:0]           k_rdata, v_rdata;

	logic [3:0]  l2;
	logic [15:0] hmask;
	logic [15:0] hsel;
	logic        res_v_q;
	result_t     res_q;

	always_comb begin
		l2 = log2_q;
		if (l2 < 4'd2) l2 = 4'd2;
		if (32'(l2) > SLOTS_LOG2) l2 = 4'(SLOTS_LOG2);
		hmask = 16'((17'd1 << l2) >> 1) - 16'd1;
		hsel  = odd_q ? hrsp.odd_c[15:0] : hrsp.even_h;
	end

	assign store_full = 32'(count_q) > ENTRY_CAPACITY;

	cuckoo_hash u_hash (.clk(clk), .arst_n(arst_n), .req(hreq), .rsp(hrsp));

	// entries are written only in idle, straight from the command port
	cuckoo_ram #(.WIDTH(EW), .DEPTH(SD)) u_slots (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
	cuckoo_ram #(.WIDTH(64), .DEPTH(ED)) u_keys (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(cmd.key), .rdata(k_rdata));
	cuckoo_ram #(.WIDTH(64), .DEPTH(ED)) u_vals (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(cmd.value), .rdata(v_rdata));

	assign busy      = state_q != S_IDLE;
	assign cfg_ready = !busy;
	assign result_valid = res_v_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		hreq.start = 1'b0;
		// first hash takes the key from the port, later insert hashes the carried entry's key
		if (state_q == S_IDLE) hreq.key = cmd.key;
		else if (cmd_q.operation == OP_FIND) hreq.key = cmd_q.key;
		else hreq.key = k_rdata;
		s_we = 1'b0; s_addr = slot_q; s_wdata = carried_q;
		e_we = 1'b0; e_addr = (cmd_q.operation == OP_FIND) ? i1_q : carried_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (cmd.operation == OP_INSERT && store_full) state_d = S_DONE;
					else state_d = S_HASH;
				end
			end
			S_CLEAR: begin
				s_we = 1'b1; s_addr = clr_q; s_wdata = '0;
				if (clr_q == SLOTS_LOG2'(SD - 1)) state_d = S_IDLE;
			end
			S_HASH: if (hrsp.done) state_d = S_SLOT_RD;
			S_SLOT_RD: state_d = S_SLOT_WAIT;
			S_SLOT_WAIT: begin
				if (cmd_q.operation == OP_FIND) begin
					if (s_rdata != '0) state_d = S_ENTRY_RD;
					else if (!odd_q) state_d = S_HASH;
					else state_d = S_DONE;
				end else begin
					s_we = 1'b1;
					state_d = S_ENTRY_RD;
				end
			end
			S_ENTRY_RD: begin
				state_d = S_ENTRY_WAIT;
			end
			S_ENTRY_WAIT: begin
				if (cmd_q.operation == OP_FIND) state_d = S_FIND_CHECK;
				else if (carried_q == '0 || 32'(pushes_q) == 2 * MAX_ROUNDS) state_d = S_DONE;
				else state_d = S_HASH;
			end
			S_FIND_CHECK: begin
				if (k_rdata == cmd_q.key || odd_q) state_d = S_DONE;
				else state_d = S_HASH;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (state_d == S_HASH && state_q != S_HASH) hreq.start = 1'b1;
		if (state_q == S_IDLE && start && cmd.operation == OP_INSERT && !store_full) begin
			e_we = 1'b1; e_addr = count_q[EW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q  <= 4'd11;
			count_q <= (EW + 1)'(1);
			clr_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			res_v_q <= 1'b0;
			if (cfg_valid && cfg_ready) log2_q <= cfg_data;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_IDLE && start && cmd.operation == OP_INSERT && !store_full)
				count_q <= count_q + 1'b1;
			if (state_q == S_DONE) res_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= cmd; odd_q <= 1'b0;
				res_q.found_value <= 64'd0;
				res_q.dropped_key <= 64'd0;
				if (start && cmd.operation == OP_INSERT && store_full) begin
					res_q.status <= ST_FULL;
					carried_q <= '0;
					pushes_q <= RW'(2 * MAX_ROUNDS);
				end else begin
					res_q.status <= ST_OK;
					carried_q <= count_q[EW-1:0];
					pushes_q <= '0;
				end
			end
			S_HASH: if (hrsp.done)
				slot_q <= SLOTS_LOG2'({hsel & hmask, odd_q});
			S_SLOT_WAIT: begin
				if (cmd_q.operation == OP_FIND) begin
					i1_q <= s_rdata;
					if (s_rdata == '0) begin
						odd_q <= 1'b1;
						if (odd_q) res_q.status <= ST_NOT_FOUND;
					end
				end else begin
					carried_q <= s_rdata;
					pushes_q <= pushes_q + 1'b1;
					odd_q <= !odd_q;
				end
			end
			S_ENTRY_WAIT: if (cmd_q.operation == OP_INSERT) begin
				if (carried_q != '0 && 32'(pushes_q) == 2 * MAX_ROUNDS) begin
					res_q.status <= ST_DROPPED;
					res_q.dropped_key <= k_rdata;
				end
			end
			S_FIND_CHECK: begin
				if (k_rdata == cmd_q.key) res_q.found_value <= v_rdata;
				else begin
					odd_q <= 1'b1;
					if (odd_q) res_q.status <= ST_NOT_FOUND;
				end
			end
			default: ;
		endcase
	end

	// short insert on store full bypasses the walk
	property p_full_no_write;
		@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start && 32'(count_q) > ENTRY_CAPACITY) |-> !e_we;
	endproperty
	a_full: assert property (p_full_no_write) else $error("write with store full");
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q) == S_DONE) else $error("stray result");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0) else $error("entry count wrapped");
endmodule

// ===== test/tb_cuckoo_hash_table.sv =====
// tb_cuckoo_hash_table: self-checking testbench for the cuckoo hash table
// depends on cuckoo_pkg and cuckoo_hash_table; a directed table, then random phases and a store fill
`timescale 1ns / 100ps

module tb_cuckoo_hash_table;
	import cuckoo_pkg::*;

	localparam int SLOT_DEPTH  = 2048;
	localparam int STORE_DEPTH = 1024;
	localparam int IDLE_LIMIT  = 20000;
	localparam logic [63:0] ONES = '1;

	typedef struct {
		int          reg_val;   // -1 leaves the register alone
		logic [0:0]  op;
		logic [63:0] key;
		logic [63:0] value;
		bit          typed;
		logic [1:0]  st;
		logic [63:0] fv;
	} dir_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    result_valid;
	result_t result;
	logic    cfg_valid;
	logic    cfg_ready;
	logic [3:0] cfg_data;

	cuckoo_hash_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// table model
	logic [9:0]  slot_tbl [SLOT_DEPTH];
	logic [63:0] entry_key [STORE_DEPTH];
	logic [63:0] entry_val [STORE_DEPTH];
	int unsigned entry_next;
	logic [3:0]  size_reg;

	result_t     expected_q [$];
	logic [63:0] key_pool [$];
	int          errors;
	int          idle_cycles;
	bit          quiet;
	dir_row_t    dir_rows [24];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [31:0] rol(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] half_mask();
		int l;
		l = size_reg;
		if (l < 2) l = 2;
		if (l > 11) l = 11;
		return ((32'd1 << l) >> 1) - 32'd1;
	endfunction

	function automatic int unsigned even_index(input logic [63:0] k);
		logic [31:0] h;
		h = EVEN_SEED;
		for (int b = 0; b < 7; b++) h = h * LARSON_M + {24'd0, k[8*b +: 8]};
		h = (h ^ (h >> 16)) & 32'hffff;
		return (h & half_mask()) << 1;
	endfunction

	function automatic int unsigned odd_index(input logic [63:0] k);
		logic [31:0] a, b, c;
		a = ODD_SEED; b = ODD_SEED; c = ODD_SEED;
		b += k[63:32];
		a += k[31:0];
		c ^= b; c -= rol(b, 14);
		a ^= c; a -= rol(c, 11);
		b ^= a; b -= rol(a, 25);
		c ^= b; c -= rol(b, 16);
		a ^= c; a -= rol(c, 4);
		b ^= a; b -= rol(a, 14);
		c ^= b; c -= rol(b, 24);
		c ^= c >> 16;
		return 1 + ((c & half_mask()) << 1);
	endfunction

	// insert walks the carried entry through its two slots; find checks even then odd
	function automatic result_t lookup_or_insert(input cmd_t c);
		result_t     r;
		logic [9:0]  carried, tmp, i1, i2;
		int unsigned s;
		r = '0;
		if (c.operation == OP_INSERT) begin
			if (entry_next > STORE_DEPTH - 1) begin
				r.status = ST_FULL;
			end else begin
				carried = entry_next[9:0];
				entry_next++;
				entry_key[carried] = c.key;
				entry_val[carried] = c.value;
				for (int rd = 0; rd < MAX_ROUNDS_DEF && carried != 0; rd++) begin
					s = even_index(entry_key[carried]);
					tmp = slot_tbl[s]; slot_tbl[s] = carried; carried = tmp;
					if (carried == 0) break;
					s = odd_index(entry_key[carried]);
					tmp = slot_tbl[s]; slot_tbl[s] = carried; carried = tmp;
				end
				if (carried != 0) begin
					r.status = ST_DROPPED;
					r.dropped_key = entry_key[carried];
				end
			end
		end else begin
			i1 = slot_tbl[even_index(c.key)];
			i2 = slot_tbl[odd_index(c.key)];
			if (i1 != 0 && entry_key[i1] == c.key) r.found_value = entry_val[i1];
			else if (i2 != 0 && entry_key[i2] == c.key) r.found_value = entry_val[i2];
			else r.status = ST_NOT_FOUND;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", result.found_value, 64'd0);
			end else begin
				if (result.status !== expected_q[0].status)
					report_mismatch("status", 64'(result.status),
						64'(expected_q[0].status));
				if (result.found_value !== expected_q[0].found_value)
					report_mismatch("found_value", result.found_value,
						expected_q[0].found_value);
				if (result.dropped_key !== expected_q[0].dropped_key)
					report_mismatch("dropped_key", result.dropped_key,
						expected_q[0].dropped_key);
				void'(expected_q.pop_front());
			end
		end
	end

	// watchdog on cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("cuckoo_hash_table test failed");
				$finish;
			end
		end
	end

	task automatic issue(input cmd_t c, input bit typed, input result_t want);
		result_t r;
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		r = lookup_or_insert(c);
		expected_q.push_back(typed ? want : r);
		if (c.operation == OP_INSERT && r.status != ST_FULL) key_pool.push_back(c.key);
	endtask

	task automatic write_size(input logic [3:0] v);
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_reg = v;
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.value = rand_word();
		if ($urandom_range(0, 99) < 50) begin
			c.operation = OP_INSERT;
			case ($urandom_range(0, 4))
				0: c.key = (key_pool.size() > 0) ?
					key_pool[$urandom_range(0, key_pool.size() - 1)] : rand_word();
				1: c.key = {56'd0, 8'($urandom)};
				default: c.key = rand_word();
			endcase
		end else begin
			c.operation = OP_FIND;
			if (key_pool.size() > 0 && $urandom_range(0, 9) < 6)
				c.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else
				c.key = rand_word();
		end
		return c;
	endfunction

	initial begin
		cmd_t    c;
		result_t want;
		logic [3:0] phase_sizes [8];

		phase_sizes = '{4'd11, 4'd3, 4'd2, 4'd6, 4'd0, 4'd15, 4'd9, 4'd4};
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		foreach (slot_tbl[i]) slot_tbl[i] = '0;
		foreach (entry_key[i]) begin
			entry_key[i] = '0;
			entry_val[i] = '0;
		end
		entry_next = 1;
		size_reg = 4'd11;

		dir_rows = '{
			'{-1, OP_FIND,   64'd0, 64'd0, 1, ST_NOT_FOUND, 64'd0},
			'{-1, OP_INSERT, 64'd0, ONES,  1, ST_OK,        64'd0},
			'{-1, OP_FIND,   64'd0, 64'd0, 1, ST_OK,        ONES},
			'{-1, OP_INSERT, ONES,  64'd0, 1, ST_OK,        64'd0},
			'{-1, OP_FIND,   ONES,  ONES,  1, ST_OK,        64'd0},
			'{-1, OP_INSERT, 64'd1, 64'd1, 0, ST_OK, 64'd0},
			'{-1, OP_INSERT, 64'd1, 64'd2, 0, ST_OK, 64'd0},
			'{-1, OP_FIND,   64'd1, 64'd0, 0, ST_OK, 64'd0},
			'{-1, OP_FIND,   64'd2, 64'd0, 0, ST_OK, 64'd0},
			'{-1, OP_INSERT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0, ST_OK, 64'd0},
			'{-1, OP_FIND,   64'haaaaaaaaaaaaaaaa, 64'd0, 0, ST_OK, 64'd0},
			// four slots only: the walk runs out and entries get dropped
			'{ 2, OP_INSERT, 64'd10, 64'd100, 0, ST_OK, 64'd0},
			'{-1, OP_INSERT, 64'd11, 64'd101, 0, ST_OK, 64'd0},
			'{-1, OP_INSERT, 64'd12, 64'd102, 0, ST_OK, 64'd0},
			'{-1, OP_INSERT, 64'd13, 64'd103, 0, ST_OK, 64'd0},
			'{-1, OP_INSERT, 64'd14, 64'd104, 0, ST_OK, 64'd0},
			'{-1, OP_INSERT, 64'd15, 64'd105, 0, ST_OK, 64'd0},
			'{-1, OP_FIND,   64'd10, 64'd0, 0, ST_OK, 64'd0},
			'{-1, OP_FIND,   64'd12, 64'd0, 0, ST_OK, 64'd0},
			'{-1, OP_FIND,   64'd15, 64'd0, 0, ST_OK, 64'd0},
			// out-of-range sizes are clamped
			'{ 0, OP_FIND,   64'd11, 64'd0, 0, ST_OK, 64'd0},
			'{15, OP_FIND,   64'd0,  64'd0, 0, ST_OK, 64'd0},
			'{ 1, OP_INSERT, 64'd16, 64'd106, 0, ST_OK, 64'd0},
			'{11, OP_FIND,   ONES,   64'd0, 0, ST_OK, 64'd0}
		};

		@(posedge clk);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].reg_val >= 0) write_size(4'(dir_rows[i].reg_val));
			c.operation = dir_rows[i].op;
			c.key = dir_rows[i].key;
			c.value = dir_rows[i].value;
			want = '0;
			want.status = dir_rows[i].st;
			want.found_value = dir_rows[i].fv;
			issue(c, dir_rows[i].typed, want);
		end

		foreach (phase_sizes[p]) begin
			write_size(phase_sizes[p]);
			for (int n = 0; n < 40; n++) issue(random_cmd(), 0, want);
		end

		// fill the entry store until inserts are refused, no idling from here on
		write_size(4'd11);
		quiet = 1'b1;
		while (entry_next <= STORE_DEPTH + 4) begin
			c.operation = OP_INSERT;
			c.key = rand_word();
			c.value = rand_word();
			issue(c, 0, want);
			if (entry_next > STORE_DEPTH - 1) entry_next++;
		end
		for (int n = 0; n < 20; n++) issue(random_cmd(), 0, want);
		start <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("cuckoo_hash_table test passed");
		end else begin
			$display("cuckoo_hash_table test failed");
		end
		$finish;
	end

endmodule

// ===== cuckoo_hash_table.f =====
rtl/core/cuckoo_pkg.sv
rtl/core/cuckoo_ram.sv
rtl/core/cuckoo_hash.sv
rtl/core/cuckoo_hash_table.sv
test/tb_cuckoo_hash_table.sv
